### src/btgl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants, codes and item types of the glyph layout unit
package btgl_pkg;

    localparam int CODE_LO     = 32;
    localparam int CODE_HI     = 126;
    localparam int MAX_SCALE   = 64;
    localparam int TAB_CELLS   = 4;
    localparam int TABLE_DEPTH = CODE_HI - CODE_LO + 1;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    // both queues use power-of-two depths so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_LOADED   = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [2:0] REG_SCALE    = 3'd0;
    localparam logic [2:0] REG_CELL_W   = 3'd1;
    localparam logic [2:0] REG_CELL_H   = 3'd2;
    localparam logic [2:0] REG_ATLAS_W  = 3'd3;
    localparam logic [2:0] REG_ATLAS_H  = 3'd4;
    localparam logic [2:0] REG_ORIGIN_X = 3'd5;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd6;
    localparam logic [2:0] REG_FALLBACK = 3'd7;

    localparam logic signed [40:0] CUR_MAX = 41'sd549755811839;
    localparam logic signed [40:0] I32_MAX = 41'sd2147483647;
    localparam logic signed [40:0] I32_MIN = -41'sd2147483648;

    typedef enum logic [2:0] {
        K_LOAD_OK,
        K_LOAD_BAD,
        K_BEGIN,
        K_NEWLINE,
        K_TAB,
        K_GLYPH,
        K_SPACE
    } kind_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [11:0] glyph_x;
        logic [11:0] glyph_y;
        logic [7:0]  glyph_w;
        logic [7:0]  glyph_h;
        logic [7:0]  glyph_advance;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         glyph_code;
        logic signed [31:0] dest_left;
        logic signed [31:0] dest_top;
        logic signed [31:0] dest_right;
        logic signed [31:0] dest_bottom;
        logic [12:0]        src_left;
        logic [12:0]        src_top;
        logic [12:0]        src_right;
        logic [12:0]        src_bottom;
    } result_t;

    typedef struct packed {
        logic [6:0]         scale;
        logic [7:0]         cell_w;
        logic [7:0]         cell_h;
        logic [12:0]        atlas_w;
        logic [12:0]        atlas_h;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [6:0]         fallback_code;
    } cfg_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [7:0]  adv;
    } glyph_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] code;
        glyph_t     glyph;
    } cmd_t;

endpackage
`default_nettype wire

### src/btgl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// generic single-port ram with registered read
module btgl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### src/btgl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// front end: checks loads, maps characters to glyph codes and classifies each item
module btgl_front
    import btgl_pkg::*;
(
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output logic       keep,
    output cmd_t       cmd
);

    logic [12:0] x_end;
    logic [12:0] y_end;
    logic        in_range;
    logic [6:0]  code;

    assign x_end    = {1'b0, item.glyph_x} + 13'(item.glyph_w);
    assign y_end    = {1'b0, item.glyph_y} + 13'(item.glyph_h);
    assign in_range = item.char_code inside {[CODE_LO:CODE_HI]};
    assign code     = in_range ? item.char_code[6:0] : cfg.fallback_code;

    always_comb
    begin
        keep            = 1'b0;
        cmd.kind        = K_BEGIN;
        cmd.code        = '0;
        cmd.glyph.x     = item.glyph_x;
        cmd.glyph.y     = item.glyph_y;
        cmd.glyph.w     = item.glyph_w;
        cmd.glyph.h     = item.glyph_h;
        cmd.glyph.adv   = item.glyph_advance;
        case (item.op)
            OP_LOAD:
            begin
                keep     = 1'b1;
                cmd.code = item.char_code[6:0];
                if (in_range && x_end <= cfg.atlas_w && y_end <= cfg.atlas_h)
                begin
                    cmd.kind = K_LOAD_OK;
                end
                else
                begin
                    cmd.kind = K_LOAD_BAD;
                end
            end
            OP_BEGIN:
            begin
                keep     = 1'b1;
                cmd.kind = K_BEGIN;
            end
            OP_CHAR:
            begin
                case (item.char_code)
                    CHAR_CR:
                    begin
                        keep = 1'b0;
                    end
                    CHAR_LF:
                    begin
                        keep     = 1'b1;
                        cmd.kind = K_NEWLINE;
                    end
                    CHAR_TAB:
                    begin
                        keep     = 1'b1;
                        cmd.kind = K_TAB;
                    end
                    default:
                    begin
                        keep     = 1'b1;
                        cmd.code = code;
                        cmd.kind = (code == CHAR_SPACE[6:0]) ? K_SPACE : K_GLYPH;
                    end
                endcase
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/btgl_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none
// command queue between the front end and the layout back end
module btgl_cmdq
    import btgl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd,
    output cmd_t      rd_data,
    output logic      empty
);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg;
    logic [QUEUE_AW-1:0] rptr_reg;
    logic [QUEUE_AW:0]   cnt_reg;
    logic [QUEUE_AW:0]   cnt_next;

    assign full    = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### src/btgl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// back end: glyph table, scaling, cursor update and result buffer
module btgl_back
    import btgl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    q_empty,
    input  wire cmd_t    q_head,
    output logic         q_pop,
    output logic         empty,
    input  wire logic    pop,
    output result_t      result
);

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  code;
        logic [14:0] ws;
        logic [14:0] hs;
        logic [15:0] inc;
        logic [12:0] src_left;
        logic [12:0] src_top;
        logic [12:0] src_right;
        logic [12:0] src_bottom;
    } s3_t;

    // issue stage
    logic                credit;
    logic                ram_en;
    logic                ram_we;
    logic [TABLE_AW-1:0] ram_addr;
    glyph_t              ram_rdata;

    // scale stage
    logic        s2_valid_reg;
    cmd_t        s2_reg;
    glyph_t      g;
    logic [7:0]  mul_a;
    logic [14:0] mul_p;
    s3_t         s3_next;

    // cursor stage
    logic               s3_valid_reg;
    s3_t                s3_reg;
    logic signed [39:0] cursor_x_reg;
    logic signed [39:0] cursor_x_next;
    logic signed [39:0] cursor_y_reg;
    logic signed [39:0] cursor_y_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic signed [40:0] cx_w;
    logic signed [40:0] cy_w;
    logic signed [40:0] ws_w;
    logic signed [40:0] hs_w;
    logic signed [40:0] inc_w;
    logic signed [40:0] right_w;
    logic signed [40:0] bottom_w;
    logic signed [40:0] sum_x;
    logic signed [40:0] sum_y;
    logic signed [39:0] sat_x;
    logic signed [39:0] sat_y;
    logic signed [39:0] org_x;
    logic signed [39:0] org_y;
    logic               edge_ovf;
    logic               res_valid;
    result_t            res;

    // result buffer
    result_t           out_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] owptr_reg;
    logic [OUT_AW-1:0] orptr_reg;
    logic [OUT_AW:0]   out_cnt_reg;
    logic [OUT_AW:0]   out_cnt_next;
    logic              out_rd;

    // issue
    assign credit = (4'(out_cnt_reg) + 4'(s2_valid_reg) + 4'(s3_valid_reg)) < 4'(OUT_DEPTH);
    assign q_pop  = !q_empty && credit;
    assign ram_we = q_pop && (q_head.kind == K_LOAD_OK);
    assign ram_en = q_pop && (q_head.kind == K_LOAD_OK || q_head.kind == K_GLYPH
                              || q_head.kind == K_SPACE);
    assign ram_addr = TABLE_AW'(q_head.code - 7'(CODE_LO));

    btgl_ram #(
        .WIDTH($bits(glyph_t)),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(q_head.glyph),
        .rdata(ram_rdata)
    );

    // scale
    always_comb
    begin
        g = (s2_reg.kind == K_LOAD_OK) ? s2_reg.glyph : ram_rdata;
        case (s2_reg.kind)
            K_NEWLINE: mul_a = cfg.cell_h;
            K_TAB:     mul_a = cfg.cell_w;
            default:   mul_a = g.adv;
        endcase
        mul_p              = 15'(mul_a) * 15'(cfg.scale);
        s3_next.kind       = s2_reg.kind;
        s3_next.code       = s2_reg.code;
        s3_next.ws         = 15'(g.w) * 15'(cfg.scale);
        s3_next.hs         = 15'(g.h) * 15'(cfg.scale);
        s3_next.inc        = (s2_reg.kind == K_TAB) ? 16'(32'(mul_p) * TAB_CELLS)
                                                    : 16'(mul_p);
        s3_next.src_left   = 13'(g.x);
        s3_next.src_top    = 13'(g.y);
        s3_next.src_right  = 13'(g.x) + 13'(g.w);
        s3_next.src_bottom = 13'(g.y) + 13'(g.h);
    end

    // cursor
    assign cx_w     = {cursor_x_reg[39], cursor_x_reg};
    assign cy_w     = {cursor_y_reg[39], cursor_y_reg};
    assign ws_w     = {26'b0, s3_reg.ws};
    assign hs_w     = {26'b0, s3_reg.hs};
    assign inc_w    = {25'b0, s3_reg.inc};
    assign right_w  = cx_w + ws_w;
    assign bottom_w = cy_w + hs_w;
    assign sum_x    = cx_w + inc_w;
    assign sum_y    = cy_w + inc_w;
    assign sat_x    = (sum_x > CUR_MAX) ? CUR_MAX[39:0] : sum_x[39:0];
    assign sat_y    = (sum_y > CUR_MAX) ? CUR_MAX[39:0] : sum_y[39:0];
    assign org_x    = {{8{cfg.origin_x[31]}}, cfg.origin_x};
    assign org_y    = {{8{cfg.origin_y[31]}}, cfg.origin_y};
    assign edge_ovf = (cx_w < I32_MIN) || (cy_w < I32_MIN)
                      || (right_w > I32_MAX) || (bottom_w > I32_MAX);

    always_comb
    begin
        res_valid     = 1'b0;
        res           = '0;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        ovf_next      = ovf_reg;
        if (s3_valid_reg)
        begin
            case (s3_reg.kind)
                K_LOAD_OK:
                begin
                    res_valid      = 1'b1;
                    res.status     = ST_LOADED;
                    res.glyph_code = s3_reg.code;
                    res.src_left   = s3_reg.src_left;
                    res.src_top    = s3_reg.src_top;
                    res.src_right  = s3_reg.src_right;
                    res.src_bottom = s3_reg.src_bottom;
                end
                K_LOAD_BAD:
                begin
                    res_valid  = 1'b1;
                    res.status = ST_REJECTED;
                end
                K_BEGIN:
                begin
                    cursor_x_next = org_x;
                    cursor_y_next = org_y;
                    ovf_next      = 1'b0;
                end
                K_NEWLINE:
                begin
                    if (!ovf_reg)
                    begin
                        cursor_x_next = org_x;
                        cursor_y_next = sat_y;
                    end
                end
                K_TAB, K_SPACE:
                begin
                    if (!ovf_reg)
                    begin
                        cursor_x_next = sat_x;
                    end
                end
                K_GLYPH:
                begin
                    if (!ovf_reg)
                    begin
                        res_valid      = 1'b1;
                        res.glyph_code = s3_reg.code;
                        if (edge_ovf)
                        begin
                            res.status = ST_OVERFLOW;
                            ovf_next   = 1'b1;
                        end
                        else
                        begin
                            res.status      = ST_PLACED;
                            res.dest_left   = cursor_x_reg[31:0];
                            res.dest_top    = cursor_y_reg[31:0];
                            res.dest_right  = right_w[31:0];
                            res.dest_bottom = bottom_w[31:0];
                            res.src_left    = s3_reg.src_left;
                            res.src_top     = s3_reg.src_top;
                            res.src_right   = s3_reg.src_right;
                            res.src_bottom  = s3_reg.src_bottom;
                            cursor_x_next   = sat_x;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result buffer
    assign empty  = (out_cnt_reg == '0);
    assign out_rd = pop && !empty;
    assign result = out_mem_reg[orptr_reg];

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (res_valid && !out_rd)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
        else if (out_rd && !res_valid)
        begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            ovf_reg      <= 1'b0;
            owptr_reg    <= '0;
            orptr_reg    <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            s2_valid_reg <= q_pop;
            s3_valid_reg <= s2_valid_reg;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            ovf_reg      <= ovf_next;
            if (res_valid)
            begin
                owptr_reg <= owptr_reg + 1'b1;
            end
            if (out_rd)
            begin
                orptr_reg <= orptr_reg + 1'b1;
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_reg <= q_head;
        end
        if (s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (res_valid)
        begin
            out_mem_reg[owptr_reg] <= res;
        end
    end

    a_buffer_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (4'(out_cnt_reg) + 4'(s2_valid_reg) + 4'(s3_valid_reg)) <= 4'(OUT_DEPTH))
        else $error("result buffer overcommitted");

    a_quiet_after_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && s3_valid_reg && (s3_reg.kind == K_GLYPH) |-> !res_valid)
        else $error("glyph result while overflow is pending");

    a_load_reaches_scale: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> s2_valid_reg && (s2_reg.kind == K_LOAD_OK))
        else $error("table write without matching load item");

    a_cursor_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        cx_w <= CUR_MAX && cy_w <= CUR_MAX)
        else $error("cursor above saturation limit");

endmodule
`default_nettype wire

### src/bitmap_text_glyph_layout_unit.sv
// Bitmap text glyph layout unit: loads glyph metrics and lays out text.
//
// Items enter through push/full; an item is taken when push is high and full
// is low. Results leave through empty/pop; the oldest result sits on result
// while empty is low and is taken when pop is high. Configuration writes use
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data. The user
// must write only while no item is in flight; the block does not enforce it.
// One item is taken per cycle when the result side keeps up. A result passes
// through the command queue, the glyph table read, then the scaling multiply
// and the 40-bit cursor add. Back-to-back characters are carried by the
// combinational cursor add; the glyph table is a single-port ram used at most
// once per item.
// Loads, rejected loads, placed glyphs and overflows give one result each;
// begin, newline, tab, carriage return, space and no-op give none.
// When pop stays low, a four-entry result buffer and a four-entry command queue
// fill and then full rises; nothing is dropped.
// Reset clears the cursor, the overflow flag, both queues and the registers to
// their defaults; the glyph table keeps no reset and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_text_glyph_layout_unit
    import btgl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire item_t       item,
    output logic             empty,
    input  wire logic        pop,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t       cfg_reg;
    logic [6:0] scale_wr;
    logic [6:0] fallback_wr;
    logic       keep;
    cmd_t       cmd;
    logic       q_wr;
    logic       q_empty;
    logic       q_pop;
    cmd_t       q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        scale_wr = cfg_data[6:0];
        if (cfg_data[6:0] == 7'd0)
        begin
            scale_wr = 7'd1;
        end
        else if (cfg_data[6:0] > 7'(MAX_SCALE))
        begin
            scale_wr = 7'(MAX_SCALE);
        end
        fallback_wr = (cfg_data[6:0] inside {[CODE_LO:CODE_HI]}) ? cfg_data[6:0]
                                                                 : 7'(CODE_LO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale         <= 7'd1;
            cfg_reg.cell_w        <= 8'd8;
            cfg_reg.cell_h        <= 8'd8;
            cfg_reg.atlas_w       <= 13'd4096;
            cfg_reg.atlas_h       <= 13'd4096;
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.fallback_code <= 7'd63;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE:    cfg_reg.scale         <= scale_wr;
                REG_CELL_W:   cfg_reg.cell_w        <= cfg_data[7:0];
                REG_CELL_H:   cfg_reg.cell_h        <= cfg_data[7:0];
                REG_ATLAS_W:  cfg_reg.atlas_w       <= cfg_data[12:0];
                REG_ATLAS_H:  cfg_reg.atlas_h       <= cfg_data[12:0];
                REG_ORIGIN_X: cfg_reg.origin_x      <= cfg_data;
                REG_ORIGIN_Y: cfg_reg.origin_y      <= cfg_data;
                REG_FALLBACK: cfg_reg.fallback_code <= fallback_wr;
                default:
                begin
                end
            endcase
        end
    end

    btgl_front u_front (
        .item(item),
        .cfg (cfg_reg),
        .keep(keep),
        .cmd (cmd)
    );

    assign q_wr = push && !full && keep;

    btgl_cmdq u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_data(cmd),
        .full   (full),
        .rd     (q_pop),
        .rd_data(q_head),
        .empty  (q_empty)
    );

    btgl_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .q_empty(q_empty),
        .q_head (q_head),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire
